// ----- rtl/core/largest_proper_divisor_top_assert.svh -----
// Assertion macros used by the checker file.
`ifndef LARGEST_PROPER_DIVISOR_TOP_ASSERT_SVH
`define LARGEST_PROPER_DIVISOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define LPD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication, disabled while reset is low.
`define LPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ----- rtl/core/lpd_pkg.sv -----
package lpd_pkg;

    // Field widths
    localparam int VALUE_W     = 31;
    localparam int DIV_W       = VALUE_W - 1;
    localparam int CNT_W       = $clog2(VALUE_W + 1);
    localparam int IDX_W       = $clog2(VALUE_W);
    localparam int IN_TDATA_W  = ((VALUE_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DIV_W + 7) / 8) * 8;

    // Request to the divider
    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] dividend;
        logic [VALUE_W-1:0] divisor;
        logic [CNT_W-1:0]   nq;        // number of quotient bits to develop
    } t_div_req;

    // Divider response
    typedef struct packed {
        logic               done;
        logic [VALUE_W-1:0] quot;
        logic               rem_zero;
    } t_div_rsp;

endpackage

// ----- rtl/core/largest_proper_divisor_top.sv -----
// Values 0, 1 and even values go from S_IDLE straight to S_PUSH, which queues the result.
// Odd values: trials over odd candidates p from 3 up to sqrt(value), one divide
// each with nq = 32 - bitlen(p) quotient bits (one-bit-per-cycle divider), then S_PUSH;
// a 31-bit prime takes about 23170 trials.
// Throughput: one request at a time; the next is taken once the result is queued.
// Reset: synchronous active-low i_rst_n; returns to idle with no result pending.
module largest_proper_divisor_top
    import lpd_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,   // [30:0] value
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0] o_m_tdata    // [29:0] divisor
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_BUSY,
        S_PUSH
    } t_state;

    t_state             r_state;
    logic               r_start;
    logic [VALUE_W-1:0] r_v;
    logic [VALUE_W-1:0] r_p;
    logic [CNT_W-1:0]   r_plen;
    logic [VALUE_W:0]   r_pow;
    logic [DIV_W-1:0]   r_res;
    logic               r_out_valid;
    logic [DIV_W-1:0]   r_out_data;

    logic [VALUE_W-1:0] w_v_in;
    logic [VALUE_W-1:0] w_p_next;
    logic               w_grow;
    logic               w_out_free;
    t_div_req           w_req;
    t_div_rsp           w_rsp;

    // Next candidate and its bit length
    always_comb begin
        w_v_in     = i_s_tdata[VALUE_W-1:0];
        w_p_next   = r_p + VALUE_W'(2);
        w_grow     = ({1'b0, w_p_next} >= r_pow);
        w_out_free = !r_out_valid || i_m_tready;
    end

    // Divider request: quotient of v / p has at most W + 1 - bitlen(p) bits
    always_comb begin
        w_req.start    = r_start;
        w_req.dividend = r_v;
        w_req.divisor  = r_p;
        w_req.nq       = CNT_W'(VALUE_W) - r_plen + CNT_W'(1);
    end

    lpd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_start     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_start <= 1'b0;
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_v <= w_v_in;
                        if (w_v_in < VALUE_W'(2)) begin
                            r_res   <= '0;
                            r_state <= S_PUSH;
                        end else if (!w_v_in[0]) begin
                            r_res   <= DIV_W'(w_v_in >> 1);
                            r_state <= S_PUSH;
                        end else begin
                            r_p     <= VALUE_W'(3);
                            r_plen  <= CNT_W'(2);
                            r_pow   <= (VALUE_W + 1)'(4);
                            r_start <= 1'b1;
                            r_state <= S_BUSY;
                        end
                    end
                end
                S_BUSY: begin
                    if (w_rsp.done) begin
                        if (w_rsp.quot < r_p) begin
                            // candidate passed the square root: prime
                            r_res   <= DIV_W'(1);
                            r_state <= S_PUSH;
                        end else if (w_rsp.rem_zero) begin
                            r_res   <= w_rsp.quot[DIV_W-1:0];
                            r_state <= S_PUSH;
                        end else begin
                            r_p     <= w_p_next;
                            r_start <= 1'b1;
                            if (w_grow) begin
                                r_plen <= r_plen + CNT_W'(1);
                                r_pow  <= r_pow << 1;
                            end
                        end
                    end
                end
                S_PUSH: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_data  <= r_res;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_TDATA_W'(r_out_data);

endmodule

// ----- rtl/core/lpd_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Starts with the top bits of the dividend already folded into the
// remainder, so only nq quotient bits are developed.
module lpd_div
    import lpd_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic               r_busy;
    logic               r_done;
    logic [IDX_W-1:0]   r_idx;
    logic [VALUE_W-1:0] r_rem;
    logic [VALUE_W-1:0] r_quo;
    logic [VALUE_W-1:0] r_v;
    logic [VALUE_W-1:0] r_p;

    logic [VALUE_W:0]   w_trial;
    logic [VALUE_W:0]   w_diff;
    logic               w_ge;
    logic [VALUE_W-1:0] n_rem;

    // One compare-subtract step
    always_comb begin
        w_trial = {r_rem, r_v[r_idx]};
        w_diff  = w_trial - {1'b0, r_p};
        w_ge    = (w_trial >= {1'b0, r_p});
        n_rem   = w_ge ? w_diff[VALUE_W-1:0] : w_trial[VALUE_W-1:0];
    end

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_v    <= i_req.dividend;
                r_p    <= i_req.divisor;
                r_rem  <= i_req.dividend >> i_req.nq;
                r_idx  <= IDX_W'(i_req.nq - CNT_W'(1));
                r_quo  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_quo <= {r_quo[VALUE_W-2:0], w_ge};
                if (r_idx == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_idx <= r_idx - IDX_W'(1);
                end
            end
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quot     = r_quo;
    assign o_rsp.rem_zero = (r_rem == '0);

endmodule

// ----- rtl/core/lpd_checker.sv -----
`include "largest_proper_divisor_top_assert.svh"

// Port-level checks on the top level.
module lpd_checker
    import lpd_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_s_tvalid,
    input logic                   o_s_tready,
    input logic [IN_TDATA_W-1:0]  i_s_tdata,
    input logic                   o_m_tvalid,
    input logic                   i_m_tready,
    input logic [OUT_TDATA_W-1:0] o_m_tdata
);

    // a stalled result holds
    `LPD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata))

    // an accepted request makes the block busy in the next cycle
    `LPD_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

    // result padding above the divisor field stays zero
    `LPD_ASSERT_NOW(a_out_pad, i_clk, i_rst_n, o_m_tvalid, (o_m_tdata >> DIV_W) == '0)

endmodule

bind largest_proper_divisor_top lpd_checker u_lpd_checker (.*);

// ----- verif/largest_proper_divisor_top_tb.sv -----
module largest_proper_divisor_top_tb;
    import lpd_pkg::*;

    localparam int MAX_WAIT = 19;
    localparam int TAIL_CYCLES = 20;
    localparam longint unsigned VALUE_MAX = (64'd1 << VALUE_W) - 1;

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata = '0;   // [30:0] value
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b1;
    logic [OUT_TDATA_W-1:0] o_m_tdata;        // [29:0] divisor

    // Expected divisors, oldest first
    logic [DIV_W-1:0] expected_divisor_q[$];
    int  fail_count = 0;
    int  values_sent = 0;
    int  results_seen = 0;
    bit  idle_off = 1'b0;   // when set, neither side inserts wait cycles
    int  ready_hold = 0;

    largest_proper_divisor_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Largest proper divisor: value over its smallest factor >= 2
    function automatic logic [DIV_W-1:0] largest_divisor_of(input logic [VALUE_W-1:0] v);
        longint unsigned n;
        longint unsigned p;
        n = v;
        if (n < 2) return '0;
        if (n[0] == 1'b0) return DIV_W'(n >> 1);
        for (p = 3; p <= n / p; p += 2) begin
            if (n % p == 0) return DIV_W'(n / p);
        end
        return DIV_W'(1);
    endfunction

    function automatic int draw_wait();
        return idle_off ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    // Send one value; valid stays high after the handshake until the next
    // call or a release, and drops between requests only for a drawn wait gap.
    task automatic send_value(input logic [VALUE_W-1:0] v);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= IN_TDATA_W'(v);
        do @(posedge i_clk); while (!o_s_tready);
        expected_divisor_q.push_back(largest_divisor_of(v));
        values_sent++;
    endtask

    task automatic release_sender();
        i_s_tvalid <= 1'b0;
    endtask

    task automatic wait_for_drain();
        release_sender();
        while (expected_divisor_q.size() != 0) @(posedge i_clk);
    endtask

    // Field extremes: zero, one, smallest primes, top bit, largest values
    task automatic test_edge_values();
        send_value(31'd0);
        send_value(31'd1);
        send_value(31'd2);
        send_value(31'd3);
        send_value(31'h4000_0000);
        send_value(31'h4000_0001);
        send_value(31'h7FFF_FFFE);
        // largest value is prime: full-length search
        send_value(31'h7FFF_FFFF);
    endtask

    task automatic test_primes();
        send_value(31'd5);
        send_value(31'd7);
        send_value(31'd97);
        send_value(31'd65521);
        send_value(31'd1048573);
    endtask

    // Composites, including squares where the factor sits right at sqrt
    task automatic test_composites();
        send_value(31'd4);
        send_value(31'd9);
        send_value(31'd25);
        send_value(31'd15);
        send_value(31'd77);
        send_value(31'd4096);
        send_value(31'd1042441);
        send_value(31'd2147483643);
    endtask

    // Sender holds off until the block has nothing outstanding, then sends with no idling
    task automatic test_drain_pause();
        repeat (4) send_value(31'($urandom_range(2, 5000)));
        wait_for_drain();
        idle_off = 1'b1;
        repeat (3) send_value(31'($urandom_range(2, 5000)));
        idle_off = 1'b0;
    endtask

    // Mix of value classes, kept cheap for the trial search except a few
    task automatic test_random_mix(input int count);
        int sel;
        int unsigned p;
        int unsigned k;
        logic [VALUE_W-1:0] v;
        for (int i = 0; i < count; i++) begin
            // toggle stretches with no idling on either side
            if (i % 16 == 0) idle_off = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 99);
            if (sel < 25) begin
                // full-range even value
                v = 31'($urandom) & 31'h7FFF_FFFE;
            end else if (sel < 55) begin
                // full-range odd multiple of a small odd factor
                p = $urandom_range(1, 49) * 2 + 1;
                k = $urandom_range(1, int'(VALUE_MAX / p));
                k = k | 32'd1;
                if (longint'(p) * k > VALUE_MAX) k = k - 2;
                v = 31'(p * k);
            end else if (sel < 75) begin
                v = 31'($urandom_range(0, 65535));
            end else if (sel < 85) begin
                v = 31'($urandom_range(0, 1 << 20)) | 31'd1;
            end else begin
                v = 31'($urandom_range(0, 63));
            end
            send_value(v);
        end
        idle_off = 1'b0;
    endtask

    // Result side: random stall while a result waits, then check it
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                results_seen++;
                if (expected_divisor_q.size() == 0) begin
                    $error("divisor: no result expected, actual %0d", o_m_tdata[DIV_W-1:0]);
                    fail_count++;
                end else begin
                    if (o_m_tdata[DIV_W-1:0] !== expected_divisor_q[0]) begin
                        $error("divisor: expected %0d, actual %0d",
                               expected_divisor_q[0], o_m_tdata[DIV_W-1:0]);
                        fail_count++;
                    end
                    void'(expected_divisor_q.pop_front());
                end
                ready_hold = draw_wait();
                if (ready_hold != 0) i_m_tready <= 1'b0;
            end else if (ready_hold != 0 && o_m_tvalid) begin
                ready_hold--;
                if (ready_hold == 0) i_m_tready <= 1'b1;
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edge_values();
        test_primes();
        test_composites();
        test_drain_pause();
        test_random_mix(72);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_divisor_q.size() != 0) begin
            $error("divisor: %0d results never arrived", expected_divisor_q.size());
            fail_count++;
        end

        $display("Covered zero, one, primes, squares, top-bit and random values: %0d sent, %0d checked",
                 values_sent, results_seen);
        if (fail_count == 0) begin
            $display("largest_proper_divisor_top verification clean");
        end else begin
            $display("largest_proper_divisor_top verification failed");
        end
        $finish;
    end

    // Watchdog, well above the slowest legal run
    initial begin
        #60_000_000;
        $display("largest_proper_divisor_top verification failed");
        $finish;
    end

endmodule

// ----- largest_proper_divisor_top.f -----
+incdir+rtl/core
rtl/core/lpd_pkg.sv
rtl/core/lpd_div.sv
rtl/core/largest_proper_divisor_top.sv
rtl/core/lpd_checker.sv
verif/largest_proper_divisor_top_tb.sv
